// File: rtl/positional_list_insert_delete_assert.svh
// assertion macros for the positional list checker
// used by pli_checker.sv; expects clk_i and rst_ni in scope
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// clocked assertion, quiet while reset is applied
`define PLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define PLI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/pli_pkg.sv
// shared types and constants for the positional list block
// no dependencies; used by every rtl file of the block but the assertion header
package pli_pkg;

  localparam int CAPACITY = 128;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = CNT_W + 9;
  localparam int GROUP    = 8;
  localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 8;

  typedef logic signed [31:0] elem_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             load;
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    elem_t            value;
  } shift_ctrl_t;

endpackage

// File: rtl/pli_cell.sv
// one storage cell of the list chain
// depends on pli_pkg
module pli_cell (
  input  logic                    clk_i,
  input  pli_pkg::shift_ctrl_t    ctrl_i,
  input  logic [pli_pkg::IDX_W-1:0] cell_idx_i,
  input  pli_pkg::elem_t          left_i,
  input  pli_pkg::elem_t          right_i,
  output pli_pkg::elem_t          value_o,
  output pli_pkg::elem_t          tap_o
);

  pli_pkg::elem_t val_q, val_d;

  // shift up on insert, shift down on delete, else hold
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (cell_idx_i == ctrl_i.idx) begin
        val_d = ctrl_i.value;
      end else if (cell_idx_i > ctrl_i.idx) begin
        val_d = left_i;
      end
    end else if (ctrl_i.del && (cell_idx_i >= ctrl_i.idx)) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  // old word of the cell being deleted, zero otherwise
  assign tap_o   = (ctrl_i.del && (cell_idx_i == ctrl_i.idx)) ? val_q : '0;
  assign value_o = val_q;

endmodule

// File: rtl/pli_chain.sv
// row of list cells plus the registered reduction of the removed word
// depends on pli_pkg and pli_cell
module pli_chain (
  input  logic                 clk_i,
  input  pli_pkg::shift_ctrl_t ctrl_i,
  output pli_pkg::elem_t       removed_o
);

  pli_pkg::elem_t cell_val [pli_pkg::CAPACITY];
  pli_pkg::elem_t cell_tap [pli_pkg::CAPACITY];
  pli_pkg::elem_t part     [pli_pkg::NGROUPS][pli_pkg::GROUP];
  pli_pkg::elem_t grp_d    [pli_pkg::NGROUPS];
  pli_pkg::elem_t grp_q    [pli_pkg::NGROUPS];

  // cells, each wired to its neighbors; ends fold back on themselves
  for (genvar i = 0; i < pli_pkg::CAPACITY; i++) begin : g_cell
    pli_pkg::elem_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_val[i];
    end else begin : g_mid_l
      assign left_w = cell_val[i-1];
    end
    if (i == pli_pkg::CAPACITY - 1) begin : g_last
      assign right_w = cell_val[i];
    end else begin : g_mid_r
      assign right_w = cell_val[i+1];
    end
    pli_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .cell_idx_i (pli_pkg::IDX_W'(i)),
      .left_i     (left_w),
      .right_i    (right_w),
      .value_o    (cell_val[i]),
      .tap_o      (cell_tap[i])
    );
  end

  // first reduction level, registered per group of cells
  for (genvar g = 0; g < pli_pkg::NGROUPS; g++) begin : g_grp
    for (genvar k = 0; k < pli_pkg::GROUP; k++) begin : g_part
      if (g * pli_pkg::GROUP + k < pli_pkg::CAPACITY) begin : g_used
        assign part[g][k] = cell_tap[g * pli_pkg::GROUP + k];
      end else begin : g_pad
        assign part[g][k] = '0;
      end
    end

    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < pli_pkg::GROUP; k++) begin
        grp_d[g] = grp_d[g] | part[g][k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.load) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  // second level over the group registers
  always_comb begin
    removed_o = '0;
    for (int g = 0; g < pli_pkg::NGROUPS; g++) begin
      removed_o = removed_o | grp_q[g];
    end
  end

endmodule

// File: rtl/positional_list_insert_delete.sv
// positional list: a result word passes the first stage, which holds the group reduction
// registers, and then the output register; no new input word is taken while the first stage
// holds a word; the cells shift in the accept cycle itself
// a result waiting at the output lets one more input word in, then holds the input
// reset clears the element count and the stage valids; cell contents are not cleared
module positional_list_insert_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: cmd [0], position [8:1], value [40:9], zero [47:41]
  input  logic [47:0] s_axis_tdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: status [1:0], removed_value [33:2], list_length [41:34], zero [47:42]
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  logic                          in_cmd;
  logic [pli_pkg::POS_W-1:0]     in_pos;
  pli_pkg::elem_t                in_value;
  logic                          accept;
  logic                          move;
  logic [pli_pkg::CMP_W-1:0]     pos_ext, cnt_ext;
  logic [8:0]                    pos_m1;
  pli_pkg::status_e              status_d;
  logic                          op_ok;
  pli_pkg::shift_ctrl_t          ctrl;
  pli_pkg::elem_t                removed;

  logic [pli_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          s1_valid_q;
  pli_pkg::status_e              s1_status_q;
  logic [pli_pkg::LEN_W-1:0]     s1_len_q;
  logic                          out_valid_q;
  pli_pkg::status_e              out_status_q;
  pli_pkg::elem_t                out_removed_q;
  logic [pli_pkg::LEN_W-1:0]     out_len_q;

  // input word unpacking
  assign in_cmd   = s_axis_tdata_i[0];
  assign in_pos   = s_axis_tdata_i[8:1];
  assign in_value = s_axis_tdata_i[40:9];

  assign s_axis_tready_o = !s1_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign move            = s1_valid_q && (!out_valid_q || m_axis_tready_i);

  // position checks against the current count
  assign pos_ext = pli_pkg::CMP_W'(in_pos);
  assign cnt_ext = pli_pkg::CMP_W'(cnt_q);
  assign pos_m1  = {1'b0, in_pos} - 9'd1;

  always_comb begin
    status_d = pli_pkg::ST_OK;
    if (in_cmd == pli_pkg::CMD_INSERT) begin
      if ((in_pos == '0) || (pos_ext > cnt_ext + pli_pkg::CMP_W'(1))) begin
        status_d = pli_pkg::ST_RANGE;
      end else if (cnt_ext >= pli_pkg::CMP_W'(pli_pkg::CAPACITY)) begin
        status_d = pli_pkg::ST_FULL;
      end
    end else begin
      if ((in_pos == '0) || (pos_ext > cnt_ext)) begin
        status_d = pli_pkg::ST_RANGE;
      end
    end
  end

  assign op_ok = accept && (status_d == pli_pkg::ST_OK);

  // control broadcast to the chain
  always_comb begin
    ctrl.load  = accept;
    ctrl.ins   = op_ok && (in_cmd == pli_pkg::CMD_INSERT);
    ctrl.del   = op_ok && (in_cmd == pli_pkg::CMD_DELETE);
    ctrl.idx   = pli_pkg::IDX_W'(pos_m1);
    ctrl.value = in_value;
  end

  // element count
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + pli_pkg::CNT_W'(1);
    end else if (ctrl.del) begin
      cnt_d = cnt_q - pli_pkg::CNT_W'(1);
    end
  end

  pli_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .removed_o (removed)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (move) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_d;
      s1_len_q    <= pli_pkg::LEN_W'(cnt_d);
    end
    if (move) begin
      out_status_q  <= s1_status_q;
      out_removed_q <= removed;
      out_len_q     <= s1_len_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_len_q, out_removed_q, out_status_q};

endmodule

// File: rtl/pli_checker.sv
// port-level checker for the positional list, bound to the top level
// depends on pli_pkg and positional_list_insert_delete_assert.svh
`include "positional_list_insert_delete_assert.svh"

module pli_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic [47:0] s_axis_tdata_i,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i
);

  // a stalled result word holds
  `PLI_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled output word changed")

  // only an ok status may carry a removed element
  `PLI_ASSERT(a_removed_zero, m_axis_tvalid_o && (m_axis_tdata_o[1:0] != 2'd0) |-> m_axis_tdata_o[33:2] == 32'd0, "removed value nonzero on error status")

  // a full status only reports a list at capacity
  `PLI_ASSERT(a_full_len, m_axis_tvalid_o && (m_axis_tdata_o[1:0] == 2'd2) |-> m_axis_tdata_o[41:34] == 8'(pli_pkg::CAPACITY), "full status with short list")

  // no output word while reset is held
  `PLI_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o || rst_ni, "output valid after reset")

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

// File: tb/sv/tb_top.sv
// testbench for positional_list_insert_delete: directed and random insert and delete words
// checked against a predictor of the list, word by word; depends on pli_pkg and the rtl top
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic           cmd;
    logic [7:0]     pos;
    pli_pkg::elem_t value;
    bit             hold;  // wait until every result is back before sending
  } list_cmd_t;

  typedef struct {
    logic [1:0]     status;
    pli_pkg::elem_t removed;
    logic [7:0]     length;
  } list_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [47:0] s_axis_tdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;

  list_cmd_t      cmd_queue[$];
  list_result_t   pending_results[$];
  pli_pkg::elem_t list_mem[pli_pkg::CAPACITY];
  int             list_len = 0;
  int             gen_len = 0;
  int             words_in = 0;
  int             errors = 0;
  bit             in_fire = 1'b0;

  positional_list_insert_delete dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // list predictor: applies one word and returns the result it must produce
  function automatic list_result_t list_apply(logic cmd, logic [7:0] pos,
                                              pli_pkg::elem_t value);
    list_result_t res;
    int p;
    res.status  = pli_pkg::ST_OK;
    res.removed = '0;
    p = int'(pos);
    if (cmd == pli_pkg::CMD_INSERT) begin
      if (p < 1 || p > list_len + 1) begin
        res.status = pli_pkg::ST_RANGE;
      end else if (list_len >= pli_pkg::CAPACITY) begin
        res.status = pli_pkg::ST_FULL;
      end else begin
        for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
        list_mem[p-1] = value;
        list_len++;
      end
    end else begin
      if (p < 1 || p > list_len) begin
        res.status = pli_pkg::ST_RANGE;
      end else begin
        res.removed = list_mem[p-1];
        for (int i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
        list_len--;
      end
    end
    res.length = list_len[7:0];
    return res;
  endfunction

  // mostly random values, with the extremes now and then
  function automatic pli_pkg::elem_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return pli_pkg::elem_t'($urandom);
    endcase
  endfunction

  // queue one word and track the length the list will have after it
  task automatic queue_word(logic cmd, int pos, pli_pkg::elem_t value, bit hold);
    list_cmd_t w;
    w.cmd   = cmd;
    w.pos   = pos[7:0];
    w.value = value;
    w.hold  = hold;
    cmd_queue.push_back(w);
    if (cmd == pli_pkg::CMD_INSERT) begin
      if (pos >= 1 && pos <= gen_len + 1 && gen_len < pli_pkg::CAPACITY) gen_len++;
    end else if (pos >= 1 && pos <= gen_len) begin
      gen_len--;
    end
  endtask

  // no idling on either side in a middle stretch of the run
  function automatic bit idle_now();
    if (words_in >= 700 && words_in < 1000) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  // sender: holds a word until taken, then loads the next one or idles
  always @(negedge clk_i) begin : sender
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_fire) begin
        if (cmd_queue.size() != 0 && !idle_now() &&
            !(cmd_queue[0].hold && pending_results.size() != 0)) begin
          s_axis_tdata_i  <= {7'd0, cmd_queue[0].value, cmd_queue[0].pos, cmd_queue[0].cmd};
          s_axis_tvalid_i <= 1'b1;
          void'(cmd_queue.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin : receiver
    m_axis_tready_i <= !idle_now();
  end

  // monitor: check results in order, then record accepted words
  always @(posedge clk_i) begin : monitor
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      in_fire = 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.status  = m_axis_tdata_o[1:0];
        got.removed = m_axis_tdata_o[33:2];
        got.length  = m_axis_tdata_o[41:34];
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual status %0d removed %0d length %0d",
                   $time, got.status, got.removed, got.length);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
          if (got.removed !== want.removed) begin
            errors++;
            $display("%0t: removed_value expected %0d actual %0d",
                     $time, want.removed, got.removed);
          end
          if (got.length !== want.length) begin
            errors++;
            $display("%0t: list_length expected %0d actual %0d", $time, want.length, got.length);
          end
        end
      end
      in_fire = s_axis_tvalid_i && s_axis_tready_o;
      if (in_fire) begin
        pending_results.push_back(list_apply(s_axis_tdata_i[0], s_axis_tdata_i[8:1],
                                             s_axis_tdata_i[40:9]));
        words_in++;
      end
    end
  end

  // reset, stimulus and end of run
  initial begin : stimulus
    int kind;
    int span;
    int roll;
    int n_rand;
    rst_ni = 1'b0;

    // directed: empty list, bad positions, extremes of value and position
    queue_word(pli_pkg::CMD_DELETE, 1, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 0, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 0, 32'sh12345678, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 2, 32'sh12345678, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 1, 32'sh7fffffff, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 1, 32'sh80000000, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 3, -32'sd1, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 2, 32'sd0, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 3, 32'sh55555555, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 255, 32'shaaaaaaaa, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 7, 32'shaaaaaaaa, 1'b0);
    queue_word(pli_pkg::CMD_INSERT, 6, 32'shaaaaaaaa, 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 7, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 255, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 3, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 5, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 1, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 2, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 1, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 1, pick_value(), 1'b0);
    queue_word(pli_pkg::CMD_DELETE, 1, pick_value(), 1'b0);

    // random phases: fill, drain or mixed, with a little noise;
    // the first one is a fill phase
    n_rand = 0;
    kind   = 0;
    span   = 170;
    while (n_rand < 1879) begin
      if (span > 1879 - n_rand) span = 1879 - n_rand;
      for (int k = 0; k < span; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          queue_word(logic'($urandom_range(0, 1)), $urandom_range(0, 255), pick_value(),
                     k == 0);
        end else if ((kind == 0 && roll < 88) || (kind == 1 && roll < 16) ||
                     (kind == 2 && roll < 53) || gen_len == 0) begin
          case ($urandom_range(0, 5))
            0: queue_word(pli_pkg::CMD_INSERT, 1, pick_value(), k == 0);
            1: queue_word(pli_pkg::CMD_INSERT, gen_len + 1, pick_value(), k == 0);
            default: queue_word(pli_pkg::CMD_INSERT, $urandom_range(1, gen_len + 1),
                                pick_value(), k == 0);
          endcase
        end else begin
          case ($urandom_range(0, 5))
            0: queue_word(pli_pkg::CMD_DELETE, 1, pick_value(), k == 0);
            1: queue_word(pli_pkg::CMD_DELETE, gen_len, pick_value(), k == 0);
            default: queue_word(pli_pkg::CMD_DELETE, $urandom_range(1, gen_len),
                                pick_value(), k == 0);
          endcase
        end
      end
      n_rand += span;
      kind = $urandom_range(0, 2);
      span = $urandom_range(40, 260);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pli_pkg.sv
rtl/pli_cell.sv
rtl/pli_chain.sv
rtl/positional_list_insert_delete.sv
rtl/pli_checker.sv
tb/sv/tb_top.sv
